// ===== sv/cosg_pkg.sv =====
// Shared types and constants for the circle outline/span generator.
package cosg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_IDX_BITS   = 2;
  localparam int QUEUE_DEPTH    = 2;
  localparam int STEP_IDX_BITS  = 3;

  // Index of the final result of one step in each mode
  localparam logic [STEP_IDX_BITS-1:0] LAST_POINT = 3'd7;
  localparam logic [STEP_IDX_BITS-1:0] LAST_SPAN  = 3'd3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CENTER_X  = 2'd0,
    CFG_CENTER_Y  = 2'd1,
    CFG_RADIUS    = 2'd2,
    CFG_FILL_MODE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/cosg_front.sv =====
// Front end: accepts items, holds the walk state and applies the decision step.
module cosg_front import cosg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_restart,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] radius,
  input  q_stat_t               q_stat,
  output logic                  push,
  output logic [COORD_BITS-1:0] push_a,
  output logic [COORD_BITS-1:0] push_c,
  output logic                  push_last
);

  localparam int W  = COORD_BITS + 2;
  localparam int SW = COORD_BITS + 4;

  logic [COORD_BITS-1:0] a_r, c_r;
  logic [W-1:0]          d_r;
  logic                  active_r;

  logic signed [SW-1:0] a_s, c_s, r_s, d_s, two_a, two_rc;
  logic signed [SW-1:0] a_n, c_n, d_n;
  logic                 walk_end, accept;

  always_comb begin
    a_s    = $signed({4'b0, a_r});
    c_s    = $signed({4'b0, c_r});
    r_s    = $signed({4'b0, radius});
    d_s    = $signed({{2{d_r[W-1]}}, d_r});
    two_a  = a_s <<< 1;
    two_rc = (r_s - c_s) <<< 1;
    a_n    = a_s;
    c_n    = c_s;
    d_n    = d_s;
    priority if (d_s >= two_a) begin
      d_n = d_s - two_a - SW'(1);
      a_n = a_s + SW'(1);
    end else if (d_s < two_rc) begin
      d_n = d_s + (c_s <<< 1) - SW'(1);
      c_n = c_s - SW'(1);
    end else begin
      d_n = d_s + ((c_s - a_s - SW'(1)) <<< 1);
      c_n = c_s - SW'(1);
      a_n = a_s + SW'(1);
    end
    walk_end = (c_n < a_n);
  end

  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !q_stat.full;
  assign push      = accept && !in_restart && active_r;
  assign push_a    = a_r;
  assign push_c    = c_r;
  assign push_last = walk_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r      <= '0;
      c_r      <= '0;
      d_r      <= '0;
      active_r <= 1'b0;
    end else if (accept) begin
      if (in_restart) begin
        a_r      <= '0;
        c_r      <= radius;
        d_r      <= {2'b0, radius} - W'(1);
        active_r <= 1'b1;
      end else if (active_r) begin
        a_r      <= a_n[COORD_BITS-1:0];
        c_r      <= c_n[COORD_BITS-1:0];
        d_r      <= d_n[W-1:0];
        active_r <= !walk_end;
      end
    end
  end

endmodule

// ===== sv/cosg_queue.sv =====
// Short job queue between the walk front end and the result sequencer.
module cosg_queue import cosg_pkg::*; #(
  parameter int DW = 2 * COORD_BITS_DEF + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] head_data,
  output q_stat_t       q_stat
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0]       mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;

  assign head_data    = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_BITS'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_BITS'(1);
      end
    end
  end

endmodule

// ===== sv/cosg_back.sv =====
// Back end: expands one walk step into points or spans, one per cycle unless stalled.
module cosg_back import cosg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [COORD_BITS-1:0]        job_a,
  input  logic [COORD_BITS-1:0]        job_c,
  input  logic                         job_last,
  input  q_stat_t                      q_stat,
  output logic                         pop,
  input  logic [COORD_BITS-1:0]        center_x,
  input  logic [COORD_BITS-1:0]        center_y,
  input  logic                         fill_mode,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS+1:0] out_start_x,
  output logic signed [COORD_BITS+1:0] out_start_y,
  output logic signed [COORD_BITS+1:0] out_end_x,
  output logic signed [COORD_BITS+1:0] out_end_y,
  output logic                         out_last_of_step,
  output logic                         out_last_of_circle
);

  localparam int W = COORD_BITS + 2;

  logic [STEP_IDX_BITS-1:0] k_r;
  logic                     out_valid_r;
  logic [W-1:0]             sx_r, sy_r, ex_r, ey_r;
  logic                     los_r, loc_r;

  logic                     load, is_last, x_uses_a, x_neg, y_neg;
  logic [STEP_IDX_BITS-1:0] last_idx;
  logic [W-1:0]             x_mag, y_mag, cx_w, cy_w;
  logic [W-1:0]             sx_nxt, sy_nxt, ex_nxt;

  always_comb begin
    last_idx = fill_mode ? LAST_SPAN : LAST_POINT;
    is_last  = (k_r == last_idx);
    load     = !q_stat.empty && (!out_valid_r || !out_stall);
    pop      = load && is_last;

    // Outline: x takes a on even points; fill: a on the middle two spans
    if (fill_mode) begin
      x_uses_a = k_r[0] ^ k_r[1];
      x_neg    = 1'b1;
      y_neg    = k_r[1];
    end else begin
      x_uses_a = !k_r[0];
      x_neg    = k_r[1];
      y_neg    = k_r[2];
    end
    x_mag  = x_uses_a ? {2'b0, job_a} : {2'b0, job_c};
    y_mag  = x_uses_a ? {2'b0, job_c} : {2'b0, job_a};
    cx_w   = {2'b0, center_x};
    cy_w   = {2'b0, center_y};
    sx_nxt = x_neg ? cx_w - x_mag : cx_w + x_mag;
    sy_nxt = y_neg ? cy_w - y_mag : cy_w + y_mag;
    ex_nxt = fill_mode ? cx_w + x_mag : sx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        k_r         <= is_last ? '0 : k_r + STEP_IDX_BITS'(1);
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      ex_r  <= ex_nxt;
      ey_r  <= sy_nxt;
      los_r <= is_last;
      loc_r <= is_last && job_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_start_x        = $signed(sx_r);
  assign out_start_y        = $signed(sy_r);
  assign out_end_x          = $signed(ex_r);
  assign out_end_y          = $signed(ey_r);
  assign out_last_of_step   = los_r;
  assign out_last_of_circle = loc_r;

  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("job popped from empty queue");

  a_idle_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> (k_r == '0))
    else $error("result index left mid-step with no job");

  a_circle_end_is_step_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && loc_r) |-> los_r)
    else $error("end of circle not on last result of step");

endmodule

// ===== sv/circle_outline_span_generator_core.sv =====
// Andres circle rasterizer: one walk step per advance transaction, emitted as
// eight outline points or four horizontal spans, one result per clock cycle
// while out_stall is low. A restart transaction reloads the walk (offset 0,
// radius) and gives no result; advance transactions after the walk has ended,
// or before any restart, give none either. The front end takes a transaction
// and updates the decision variable at once, queueing up to two pending steps;
// the result sequencer then emits eight results per step in outline mode and
// four in fill mode, so it sets the sustained rate. While a finished result
// waits on out_stall the sequencer holds, and the front end keeps accepting
// until the queue is full. Center, radius and mode come from configuration
// registers written through cfg_wr_en, cfg_index and cfg_wdata; the user must
// write them only while the block is idle, as the block does not enforce it.
module circle_outline_span_generator_core import cosg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS+1:0] out_start_x,
  output logic signed [COORD_BITS+1:0] out_start_y,
  output logic signed [COORD_BITS+1:0] out_end_x,
  output logic signed [COORD_BITS+1:0] out_end_y,
  output logic                         out_last_of_step,
  output logic                         out_last_of_circle
);

  localparam int JOB_W = 2 * COORD_BITS + 1;

  logic [COORD_BITS-1:0] center_x_r, center_y_r, radius_r;
  logic                  fill_mode_r;

  q_stat_t               q_stat;
  logic                  push, pop, push_last;
  logic [COORD_BITS-1:0] push_a, push_c;
  logic [JOB_W-1:0]      head_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= '0;
      center_y_r  <= '0;
      radius_r    <= '0;
      fill_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CENTER_X:  center_x_r  <= cfg_wdata;
        CFG_CENTER_Y:  center_y_r  <= cfg_wdata;
        CFG_RADIUS:    radius_r    <= cfg_wdata;
        CFG_FILL_MODE: fill_mode_r <= cfg_wdata[0];
      endcase
    end
  end

  cosg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_restart(in_restart),
    .in_stall  (in_stall),
    .radius    (radius_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_a    (push_a),
    .push_c    (push_c),
    .push_last (push_last)
  );

  cosg_queue #(.DW(JOB_W)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_last, push_c, push_a}),
    .pop      (pop),
    .head_data(head_data),
    .q_stat   (q_stat)
  );

  cosg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_a             (head_data[COORD_BITS-1:0]),
    .job_c             (head_data[2*COORD_BITS-1:COORD_BITS]),
    .job_last          (head_data[JOB_W-1]),
    .q_stat            (q_stat),
    .pop               (pop),
    .center_x          (center_x_r),
    .center_y          (center_y_r),
    .fill_mode         (fill_mode_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_start_x       (out_start_x),
    .out_start_y       (out_start_y),
    .out_end_x         (out_end_x),
    .out_end_y         (out_end_y),
    .out_last_of_step  (out_last_of_step),
    .out_last_of_circle(out_last_of_circle)
  );

endmodule

// ===== test/circle_outline_span_generator_core_test.sv =====
// Self-checking testbench for the circle outline/span generator core.
`timescale 1ns / 100ps

module circle_outline_span_generator_core_test;
  import cosg_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int OW = CB + 2;
  localparam int RANDOM_ITEMS = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [OW-1:0] start_x;
    logic signed [OW-1:0] start_y;
    logic signed [OW-1:0] end_x;
    logic signed [OW-1:0] end_y;
    logic                 last_of_step;
    logic                 last_of_circle;
  } span_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  cfg_reg_t             cfg_index;
  logic [CB-1:0]        cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_restart;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [OW-1:0] out_start_x;
  logic signed [OW-1:0] out_start_y;
  logic signed [OW-1:0] out_end_x;
  logic signed [OW-1:0] out_end_y;
  logic                 out_last_of_step;
  logic                 out_last_of_circle;

  // Predictor copy of the registers and the walk state
  logic [CB-1:0]        cen_x = '0;
  logic [CB-1:0]        cen_y = '0;
  logic [CB-1:0]        rad = '0;
  logic                 fill = 1'b0;
  logic [CB-1:0]        along = '0;
  logic [CB-1:0]        across = '0;
  logic signed [OW-1:0] dec = '0;
  logic                 walking = 1'b0;

  span_t pending_spans[$];
  int    errors = 0;
  int    fed_items = 0;
  int    idle_cycles = 0;
  bit    quiet = 1'b0;
  bit    hold_req = 1'b0;

  circle_outline_span_generator_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_start_x       (out_start_x),
    .out_start_y       (out_start_y),
    .out_end_x         (out_end_x),
    .out_end_y         (out_end_y),
    .out_last_of_step  (out_last_of_step),
    .out_last_of_circle(out_last_of_circle)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic span_t make_span(int sx, int sy, int ex, int ey);
    span_t s;
    s.start_x = OW'(sx);
    s.start_y = OW'(sy);
    s.end_x = OW'(ex);
    s.end_y = OW'(ey);
    s.last_of_step = 1'b0;
    s.last_of_circle = 1'b0;
    return s;
  endfunction

  // Expected results of one accepted transaction; advances the walk state
  function automatic void rasterize_step(bit restart_bit);
    span_t batch[8];
    int n, a, c, d, r, x, y;
    n = 0;
    if (restart_bit) begin
      along = '0;
      across = rad;
      dec = OW'(int'(rad) - 1);
      walking = 1'b1;
      return;
    end
    if (!walking) return;
    a = int'(along);
    c = int'(across);
    d = int'(dec);
    r = int'(rad);
    x = int'(cen_x);
    y = int'(cen_y);
    if (!fill) begin
      batch[0] = make_span(x + a, y + c, x + a, y + c);
      batch[1] = make_span(x + c, y + a, x + c, y + a);
      batch[2] = make_span(x - a, y + c, x - a, y + c);
      batch[3] = make_span(x - c, y + a, x - c, y + a);
      batch[4] = make_span(x + a, y - c, x + a, y - c);
      batch[5] = make_span(x + c, y - a, x + c, y - a);
      batch[6] = make_span(x - a, y - c, x - a, y - c);
      batch[7] = make_span(x - c, y - a, x - c, y - a);
      n = 8;
    end else begin
      batch[0] = make_span(x - c, y + a, x + c, y + a);
      batch[1] = make_span(x - a, y + c, x + a, y + c);
      batch[2] = make_span(x - a, y - c, x + a, y - c);
      batch[3] = make_span(x - c, y - a, x + c, y - a);
      n = 4;
    end
    if (d >= 2 * a) begin
      d -= 2 * a + 1;
      a += 1;
    end else if (d < 2 * (r - c)) begin
      d += 2 * c - 1;
      c -= 1;
    end else begin
      d += 2 * (c - a - 1);
      c -= 1;
      a += 1;
    end
    batch[n-1].last_of_step = 1'b1;
    // Offsets crossed: close the walk
    if (c < a) begin
      batch[n-1].last_of_circle = 1'b1;
      walking = 1'b0;
    end
    along = CB'(a);
    across = CB'(c);
    dec = OW'(d);
    for (int i = 0; i < n; i++) pending_spans.push_back(batch[i]);
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CB-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CENTER_X:  cen_x = val;
      CFG_CENTER_Y:  cen_y = val;
      CFG_RADIUS:    rad = val;
      CFG_FILL_MODE: fill = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_item(bit rs);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (rs || walking) fed_items++;
    rasterize_step(rs);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected result is out and the core is quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_idle_and_zero_radius();
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    settle();
  endtask

  task automatic check_coordinate_extremes();
    write_reg(CFG_CENTER_X, '1);
    write_reg(CFG_CENTER_Y, '1);
    write_reg(CFG_RADIUS, '1);
    write_reg(CFG_FILL_MODE, 12'h000);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    settle();
    write_reg(CFG_CENTER_X, '0);
    write_reg(CFG_CENTER_Y, '0);
    write_reg(CFG_FILL_MODE, 12'h001);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    settle();
  endtask

  // Walk left active from the previous test; change registers between steps
  task automatic check_live_registers();
    write_reg(CFG_CENTER_X, 12'd2048);
    write_reg(CFG_FILL_MODE, 12'hFFE);
    send_item(1'b0);
    settle();
    write_reg(CFG_RADIUS, 12'd10);
    send_item(1'b0);
    settle();
    write_reg(CFG_FILL_MODE, 12'h001);
    send_item(1'b0);
    settle();
  endtask

  task automatic check_small_circles();
    int steps;
    write_reg(CFG_CENTER_X, 12'd100);
    write_reg(CFG_CENTER_Y, 12'd100);
    write_reg(CFG_RADIUS, 12'd3);
    write_reg(CFG_FILL_MODE, 12'h000);
    for (int m = 0; m < 2; m++) begin
      steps = 0;
      send_item(1'b1);
      while (walking && steps < 10) begin
        send_item(1'b0);
        steps++;
      end
      settle();
      write_reg(CFG_FILL_MODE, 12'h001);
    end
  endtask

  task automatic check_backpressure();
    write_reg(CFG_RADIUS, 12'd200);
    write_reg(CFG_FILL_MODE, 12'h000);
    quiet = 1'b1;
    send_item(1'b1);
    hold_req = 1'b1;
    repeat (20) send_item(1'b0);
    quiet = 1'b0;
    settle();
  endtask

  task automatic check_random_walks();
    int target, kind, steps, sel;
    target = fed_items + RANDOM_ITEMS;
    while (fed_items < target) begin
      settle();
      quiet = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 9);
      if ($urandom_range(0, 3) != 0)
        write_reg(CFG_CENTER_X, sel == 0 ? '0 : sel == 1 ? '1 : CB'($urandom));
      sel = $urandom_range(0, 9);
      if ($urandom_range(0, 3) != 0)
        write_reg(CFG_CENTER_Y, sel == 0 ? '0 : sel == 1 ? '1 : CB'($urandom));
      sel = $urandom_range(0, 19);
      if ($urandom_range(0, 3) != 0)
        write_reg(CFG_RADIUS, sel == 0 ? '0 : sel == 1 ? '1 :
                  sel == 2 ? CB'($urandom_range(100, 4095)) : CB'($urandom_range(1, 24)));
      if ($urandom_range(0, 1) != 0) write_reg(CFG_FILL_MODE, CB'($urandom));
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        // noise: random mix of restarts and advances
        repeat (10) send_item($urandom_range(0, 3) == 0);
      end else begin
        send_item(1'b1);
        if (kind >= 7) begin
          // broken walk: restart again partway through
          repeat ($urandom_range(0, 5)) send_item(1'b0);
          send_item(1'b1);
        end
        steps = 0;
        while (walking && steps < 40) begin
          send_item(1'b0);
          steps++;
        end
        repeat ($urandom_range(0, 2)) send_item(1'b0);
      end
    end
    quiet = 1'b0;
  endtask

  // Receiver: random stall runs, plus one long hold on request
  initial begin : rx_side
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        n = pick_gap();
        out_stall <= (n != 0);
        repeat (n) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    span_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_start_x, out_start_y, out_end_x, out_end_y,
              out_last_of_step, out_last_of_circle};
      if (pending_spans.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t unexpected result %0d %0d %0d %0d %b%b", $time,
                   got.start_x, got.start_y, got.end_x, got.end_y,
                   got.last_of_step, got.last_of_circle);
      end else begin
        want = pending_spans.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t got %0d %0d %0d %0d %b%b want %0d %0d %0d %0d %b%b", $time,
                     got.start_x, got.start_y, got.end_x, got.end_y,
                     got.last_of_step, got.last_of_circle,
                     want.start_x, want.start_y, want.end_x, want.end_y,
                     want.last_of_step, want.last_of_circle);
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("circle_outline_span_generator_core_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_CENTER_X;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_restart = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    check_idle_and_zero_radius();
    check_coordinate_extremes();
    check_live_registers();
    check_small_circles();
    check_backpressure();
    check_random_walks();
    settle();
    if (errors == 0) begin
      $display("circle_outline_span_generator_core_test: done, clean");
    end else begin
      $display("circle_outline_span_generator_core_test: done, errors");
    end
    $finish;
  end

endmodule
